// File: design/gtt_pkg.sv
// ----------------------------------------------------------------------------
// gtt_pkg
// Shared types, codes and character constants of the grammar text tokenizer.
// ----------------------------------------------------------------------------
package gtt_pkg;

  localparam int MAX_LEXEME_DEF    = 32;
  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_RESULTS       = 64;
  localparam int RES_W             = $clog2(MAX_RESULTS + 1);

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 4;
  localparam int OUT_POS_W = 16;
  localparam int OUT_LEN_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT   = 4'd0,
    KIND_STRING  = 4'd1,
    KIND_EPSILON = 4'd2,
    KIND_ARROW   = 4'd3,
    KIND_BAR     = 4'd4,
    KIND_AMP     = 4'd5,
    KIND_TILDE   = 4'd6,
    KIND_SEMI    = 4'd7,
    KIND_END     = 4'd8,
    KIND_INVALID = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_DASH
  } mode_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_FEED,
    ST_RD,
    ST_LD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic feed;
    logic rd_first;
    logic advance;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic retry;
    logic last;
    logic drop;
  } sts_t;

  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [BYTE_W-1:0] CH_DASH       = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_GT         = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_BAR        = 8'h7c;
  localparam logic [BYTE_W-1:0] CH_AMP        = 8'h26;
  localparam logic [BYTE_W-1:0] CH_TILDE      = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_SEMI       = 8'h3b;
  localparam logic [BYTE_W-1:0] CH_QUOTE      = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH     = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF         = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR         = 8'h0d;

  localparam logic [7*BYTE_W-1:0] KW_EPSILON = "epsilon";
  localparam logic [3*BYTE_W-1:0] LX_EOF     = "EOF";
  localparam int                  KW_EPS_LEN = 7;

  function automatic logic is_word(input logic [BYTE_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDERSCORE;
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// File: design/gtt_ram.sv
// ----------------------------------------------------------------------------
// gtt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/gtt_ctrl.sv
// ----------------------------------------------------------------------------
// gtt_ctrl
// Sequencer: takes a transaction, runs one or two lexer passes over it and
// walks each finished token out one result at a time.
// ----------------------------------------------------------------------------
module gtt_ctrl
  import gtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   retry_r, retry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      pass_r  <= 1'b0;
      retry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      retry_r <= retry_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    retry_nxt = retry_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_WAIT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pass_nxt    = 1'b0;
          state_nxt   = ST_FEED;
        end
      end
      ST_FEED: begin
        cmd.feed  = 1'b1;
        pass_nxt  = 1'b1;
        retry_nxt = sts.retry && !pass_r;
        if (sts.emit) begin
          state_nxt = ST_RD;
        end else if (sts.retry && !pass_r) begin
          state_nxt = ST_FEED;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_RD: begin
        cmd.rd_first = 1'b1;
        state_nxt    = ST_LD;
      end
      ST_LD: begin
        if (sts.drop) begin
          state_nxt = retry_r ? ST_FEED : ST_WAIT;
        end else begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = retry_r ? ST_FEED : ST_WAIT;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_LD;
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

endmodule

// File: design/gtt_dpath.sv
// ----------------------------------------------------------------------------
// gtt_dpath
// Lexer datapath: position counters, lexer mode, lexeme buffer, token
// descriptor and result register.
// ----------------------------------------------------------------------------
module gtt_dpath
  import gtt_pkg::*;
#(
  parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_eof,
  output logic [KIND_W-1:0]    out_token_kind,
  output logic [OUT_POS_W-1:0] out_token_line,
  output logic [OUT_POS_W-1:0] out_token_column,
  output logic [OUT_LEN_W-1:0] out_lexeme_length,
  output logic [BYTE_W-1:0]    out_lexeme_byte,
  output logic                 out_truncated,
  output logic                 out_last_of_token
);

  localparam int P     = POSITION_BITS;
  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int AW    = $clog2(MAX_LEXEME);
  localparam int CW    = ((P > LEN_W) ? P : LEN_W) + 1;

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] v, input logic [1:0] n);
    logic [P:0] s;
    s = {1'b0, v} + (P+1)'(n);
    return s[P] ? '1 : s[P-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] kw_byte(input logic [2:0] i);
    return KW_EPSILON[BYTE_W*(KW_EPS_LEN-1-int'(i)) +: BYTE_W];
  endfunction

  // lexer state
  logic [BYTE_W-1:0] byte_r;
  logic              eof_r;
  mode_t             mode_r, mode_f;
  logic [P-1:0]      line_r, line_f;
  logic [P-1:0]      col_r, col_f;
  logic [LEN_W-1:0]  len_r, len_f;
  logic              ovf_r, ovf_f;
  logic              eps_r, eps_f;

  // token descriptor
  kind_t             tok_kind_r;
  logic [P-1:0]      tok_line_r;
  logic [P-1:0]      tok_col_r;
  logic [LEN_W-1:0]  tok_len_r;
  logic              tok_trunc_r;
  logic              tok_store_r;
  logic [BYTE_W-1:0] tok_byte_r;
  logic [AW-1:0]     idx_r;
  logic [RES_W-1:0]  res_cnt_r;

  // feed decode
  logic              emit, retry, clr, app_en, app_clear;
  logic [BYTE_W-1:0] app_byte;
  kind_t             e_kind;
  logic [LEN_W-1:0]  e_len;
  logic              e_trunc, e_store;
  logic [BYTE_W-1:0] e_byte;
  logic [P-1:0]      e_col;
  logic [LEN_W-1:0]  base_len;
  logic              base_ovf, base_eps;
  logic [CW-1:0]     need, colx;

  // lexeme buffer
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] const_byte;
  logic              last;

  always_comb begin
    mode_f    = mode_r;
    line_f    = line_r;
    col_f     = col_r;
    emit      = 1'b0;
    retry     = 1'b0;
    clr       = 1'b0;
    app_en    = 1'b0;
    app_clear = 1'b0;
    app_byte  = byte_r;
    e_kind    = KIND_INVALID;
    e_len     = len_r;
    e_trunc   = 1'b0;
    e_store   = 1'b0;
    e_byte    = byte_r;
    unique case (mode_r)
      MODE_IDENT: begin
        if (!eof_r && is_word(byte_r)) begin
          app_en = 1'b1;
          col_f  = sat_add(col_r, 2'd1);
        end else begin
          emit   = 1'b1;
          clr    = 1'b1;
          retry  = 1'b1;
          mode_f = MODE_IDLE;
          if (!ovf_r && len_r == LEN_W'(KW_EPS_LEN) && eps_r) begin
            e_kind = KIND_EPSILON;
            e_len  = '0;
          end else begin
            e_kind  = KIND_IDENT;
            e_trunc = ovf_r;
            e_store = 1'b1;
          end
        end
      end
      MODE_STRING: begin
        if (eof_r) begin
          emit    = 1'b1;
          clr     = 1'b1;
          retry   = 1'b1;
          mode_f  = MODE_IDLE;
          e_kind  = KIND_INVALID;
          e_trunc = ovf_r;
          e_store = 1'b1;
        end else if (byte_r == CH_QUOTE) begin
          col_f   = sat_add(col_r, 2'd1);
          emit    = 1'b1;
          clr     = 1'b1;
          mode_f  = MODE_IDLE;
          e_kind  = (len_r == '0 && !ovf_r) ? KIND_EPSILON : KIND_STRING;
          e_trunc = ovf_r;
          e_store = 1'b1;
        end else if (byte_r == CH_BSLASH) begin
          mode_f = MODE_ESCAPE;
        end else begin
          app_en = 1'b1;
          col_f  = sat_add(col_r, 2'd1);
        end
      end
      MODE_ESCAPE: begin
        mode_f = MODE_STRING;
        app_en = 1'b1;
        if (!eof_r && byte_r == CH_QUOTE) begin
          app_byte = CH_QUOTE;
          col_f    = sat_add(col_r, 2'd2);
        end else begin
          app_byte = CH_BSLASH;
          col_f    = sat_add(col_r, 2'd1);
          retry    = 1'b1;
        end
      end
      MODE_DASH: begin
        mode_f = MODE_IDLE;
        emit   = 1'b1;
        if (!eof_r && byte_r == CH_GT) begin
          col_f  = sat_add(col_r, 2'd2);
          e_kind = KIND_ARROW;
          e_len  = LEN_W'(2);
        end else begin
          col_f  = sat_add(col_r, 2'd1);
          e_kind = KIND_INVALID;
          e_len  = LEN_W'(1);
          e_byte = CH_DASH;
          retry  = 1'b1;
        end
      end
      default: begin
        mode_f = MODE_IDLE;
        if (eof_r) begin
          col_f  = sat_add(col_r, 2'd1);
          emit   = 1'b1;
          e_kind = KIND_END;
          e_len  = LEN_W'(3);
        end else if (is_space(byte_r)) begin
          if (byte_r == CH_LF || byte_r == CH_CR) begin
            line_f = sat_add(line_r, 2'd1);
            col_f  = P'(1);
          end else begin
            col_f = sat_add(col_r, 2'd1);
          end
        end else if (byte_r == CH_QUOTE) begin
          col_f  = sat_add(col_r, 2'd1);
          clr    = 1'b1;
          mode_f = MODE_STRING;
        end else if (is_word(byte_r)) begin
          app_en    = 1'b1;
          app_clear = 1'b1;
          col_f     = sat_add(col_r, 2'd1);
          mode_f    = MODE_IDENT;
        end else if (byte_r == CH_DASH) begin
          mode_f = MODE_DASH;
        end else begin
          col_f = sat_add(col_r, 2'd1);
          emit  = 1'b1;
          e_len = LEN_W'(1);
          case (byte_r)
            CH_BAR:   e_kind = KIND_BAR;
            CH_AMP:   e_kind = KIND_AMP;
            CH_TILDE: e_kind = KIND_TILDE;
            CH_SEMI:  e_kind = KIND_SEMI;
            default:  e_kind = KIND_INVALID;
          endcase
        end
      end
    endcase
  end

  // lexeme append and clear
  always_comb begin
    base_len  = app_clear ? '0 : len_r;
    base_ovf  = app_clear ? 1'b0 : ovf_r;
    base_eps  = app_clear ? 1'b1 : eps_r;
    len_f     = len_r;
    ovf_f     = ovf_r;
    eps_f     = eps_r;
    ram_we    = 1'b0;
    ram_waddr = base_len[AW-1:0];
    if (clr) begin
      len_f = '0;
      ovf_f = 1'b0;
      eps_f = 1'b1;
    end else if (app_en) begin
      if (base_len < LEN_W'(MAX_LEXEME)) begin
        ram_we = cmd.feed;
        len_f  = base_len + LEN_W'(1);
        ovf_f  = base_ovf;
        eps_f  = base_eps && base_len < LEN_W'(KW_EPS_LEN) &&
                 app_byte == kw_byte(base_len[2:0]);
      end else begin
        len_f = base_len;
        ovf_f = 1'b1;
        eps_f = base_eps;
      end
    end
  end

  // column of the token start, clamped at zero
  always_comb begin
    need  = CW'(e_len) + CW'(1);
    colx  = CW'(col_f);
    e_col = (colx > need) ? P'(colx - need) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      line_r    <= P'(1);
      col_r     <= P'(1);
      len_r     <= '0;
      ovf_r     <= 1'b0;
      eps_r     <= 1'b1;
      idx_r     <= '0;
      res_cnt_r <= '0;
    end else begin
      if (cmd.feed) begin
        mode_r <= mode_f;
        line_r <= line_f;
        col_r  <= col_f;
        len_r  <= len_f;
        ovf_r  <= ovf_f;
        eps_r  <= eps_f;
        if (emit) begin
          idx_r <= '0;
        end
      end
      if (cmd.advance) begin
        idx_r <= idx_r + AW'(1);
      end
      if (cmd.load_in) begin
        res_cnt_r <= '0;
      end else if (cmd.ld_out) begin
        res_cnt_r <= res_cnt_r + RES_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_byte;
      eof_r  <= in_eof;
    end
    if (cmd.feed && emit) begin
      tok_kind_r  <= e_kind;
      tok_line_r  <= line_f;
      tok_col_r   <= e_col;
      tok_len_r   <= e_len;
      tok_trunc_r <= e_trunc;
      tok_store_r <= e_store;
      tok_byte_r  <= e_byte;
    end
  end

  assign ram_re    = cmd.rd_first | cmd.advance;
  assign ram_raddr = cmd.advance ? idx_r + AW'(1) : idx_r;

  gtt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEXEME)
  ) u_lexeme_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (app_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (tok_kind_r)
      KIND_END:   const_byte = LX_EOF[BYTE_W*(2-int'(idx_r[1:0])) +: BYTE_W];
      KIND_ARROW: const_byte = (idx_r == '0) ? CH_DASH : CH_GT;
      default:    const_byte = tok_byte_r;
    endcase
  end

  assign last = (tok_len_r == '0) || (LEN_W'(idx_r) + LEN_W'(1) == tok_len_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_token_kind    <= tok_kind_r;
      out_token_line    <= OUT_POS_W'(tok_line_r);
      out_token_column  <= OUT_POS_W'(tok_col_r);
      out_lexeme_length <= OUT_LEN_W'(tok_len_r);
      out_truncated     <= tok_trunc_r;
      out_last_of_token <= last;
      if (tok_len_r == '0) begin
        out_lexeme_byte <= '0;
      end else if (tok_store_r) begin
        out_lexeme_byte <= ram_rdata;
      end else begin
        out_lexeme_byte <= const_byte;
      end
    end
  end

  assign sts.emit  = emit;
  assign sts.retry = retry;
  assign sts.last  = last;
  assign sts.drop  = (res_cnt_r == RES_W'(MAX_RESULTS));

endmodule

// File: design/grammar_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// grammar_text_tokenizer_core
// Lexer for BNF-style grammar text, one byte or end mark per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one text byte or an end-of-input mark. One
// transaction is worked on at a time: it is accepted and gets one lexer pass,
// and one more when the byte that ends a token is lexed again. Every
// finished token then leaves as a run of result transactions, one per lexeme
// byte (one result for an empty lexeme). A run opens with one buffer read and
// then moves each result through a load step and an output step, holding it
// while the result side stalls; the next result is loaded only after the last
// is taken. That order is set by the registered read of the single lexeme
// buffer followed by the result register. No new input is taken while a run
// is going out. The lexeme buffer needs no clearing after reset.
module grammar_text_tokenizer_core
  import gtt_pkg::*;
#(
  parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_token_kind,
  output logic [OUT_POS_W-1:0] out_token_line,
  output logic [OUT_POS_W-1:0] out_token_column,
  output logic [OUT_LEN_W-1:0] out_lexeme_length,
  output logic [BYTE_W-1:0]    out_lexeme_byte,
  output logic                 out_truncated,
  output logic                 out_last_of_token
);

  cmd_t cmd;
  sts_t sts;

  gtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gtt_dpath #(
    .MAX_LEXEME    (MAX_LEXEME),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_byte           (in_byte),
    .in_eof            (in_end_of_input),
    .out_token_kind    (out_token_kind),
    .out_token_line    (out_token_line),
    .out_token_column  (out_token_column),
    .out_lexeme_length (out_lexeme_length),
    .out_lexeme_byte   (out_lexeme_byte),
    .out_truncated     (out_truncated),
    .out_last_of_token (out_last_of_token)
  );

endmodule

// File: design/gtt_checker.sv
// ----------------------------------------------------------------------------
// gtt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module gtt_checker
  import gtt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [KIND_W-1:0]    out_token_kind,
  input logic [OUT_POS_W-1:0] out_token_line,
  input logic [OUT_POS_W-1:0] out_token_column,
  input logic [OUT_LEN_W-1:0] out_lexeme_length,
  input logic [BYTE_W-1:0]    out_lexeme_byte,
  input logic                 out_truncated,
  input logic                 out_last_of_token
);

  a_out_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_token_kind) && $stable(out_token_line) &&
      $stable(out_token_column) && $stable(out_lexeme_length) &&
      $stable(out_lexeme_byte) && $stable(out_truncated) && $stable(out_last_of_token))
    else $error("result payload changed while stalled");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_empty_lexeme_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lexeme_length == '0 |-> out_last_of_token && out_lexeme_byte == '0)
    else $error("empty lexeme not a single zero result");

  a_end_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END |->
      out_lexeme_length == OUT_LEN_W'(3) && !out_truncated)
    else $error("end token with wrong lexeme");

endmodule

bind grammar_text_tokenizer_core gtt_checker u_gtt_checker (.*);
